>>> design/apy440_pkg.sv
package apy440_pkg;

  localparam int MAX_WIDTH_DEF = 2048;
  localparam int IMG_W         = 12;
  localparam int MODE_W        = 2;

  localparam logic [IMG_W-1:0] IMAGE_WIDTH_RST = IMG_W'(2048);

  localparam logic [MODE_W-1:0] MODE_GM = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RC = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BY = 2'd2;

  localparam logic REG_ANAGLYPH_MODE = 1'b0;
  localparam logic REG_IMAGE_WIDTH   = 1'b1;

  // bt.601 fixed point, 14 bit fraction
  localparam int Y_B        = 1868;
  localparam int Y_G        = 9617;
  localparam int Y_R        = 4899;
  localparam int CR_K       = 11682;
  localparam int CB_K       = 9241;
  localparam int ROUND_HALF = 8192;
  localparam int CHROMA_OFS = 128 * 16384 + 8192;

  typedef struct packed {
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
  } pix_t;

  typedef struct packed {
    logic adv_luma;
    logic adv_chroma;
  } csc_ctl_t;

endpackage

>>> design/apy440_csc.sv
module apy440_csc (
  input  logic                clk,
  input  apy440_pkg::csc_ctl_t ctl,
  input  apy440_pkg::pix_t    pix,
  output logic [7:0]          y,
  output logic [7:0]          cr,
  output logic [7:0]          cb
);
  import apy440_pkg::*;

  localparam logic signed [24:0] KCR  = 25'(CR_K);
  localparam logic signed [24:0] KCB  = 25'(CB_K);
  localparam logic signed [24:0] COFS = 25'(CHROMA_OFS);

  logic [21:0]        ysum;
  logic [7:0]         y2;
  logic [7:0]         b2;
  logic [7:0]         r2;
  logic signed [9:0]  dr;
  logic signed [9:0]  db;
  logic signed [24:0] crx;
  logic signed [24:0] cbx;
  logic [7:0]         cr_sat;
  logic [7:0]         cb_sat;

  assign ysum = 22'(Y_B * int'(pix.b) + Y_G * int'(pix.g) + Y_R * int'(pix.r) + ROUND_HALF);

  always_ff @(posedge clk) begin
    if (ctl.adv_luma) begin
      y2 <= ysum[21:14];
      b2 <= pix.b;
      r2 <= pix.r;
    end
  end

  assign dr  = $signed({2'b00, r2}) - $signed({2'b00, y2});
  assign db  = $signed({2'b00, b2}) - $signed({2'b00, y2});
  assign crx = 25'(dr) * KCR + COFS;
  assign cbx = 25'(db) * KCB + COFS;

  always_comb begin
    if (crx[24]) cr_sat = 8'd0;
    else if (|crx[23:22]) cr_sat = 8'd255;
    else cr_sat = crx[21:14];
    if (cbx[24]) cb_sat = 8'd0;
    else if (|cbx[23:22]) cb_sat = 8'd255;
    else cb_sat = cbx[21:14];
  end

  always_ff @(posedge clk) begin
    if (ctl.adv_chroma) begin
      y  <= y2;
      cr <= cr_sat;
      cb <= cb_sat;
    end
  end

endmodule

>>> design/anaglyph_pair_ycrcb_440_top.sv
// Stereo anaglyph encoder with YCrCb 4:4:0 chroma subsampling.
// Input channel (in_valid / in_stall): one left and one right BGR pixel per
// transfer, in raster order. Output channel (out_valid / out_stall): one
// result per input transfer, in the same order: both lumas, their wrapped
// difference and, on odd rows, chroma averaged with the even row above.
// Configuration (cfg_valid / cfg_ready, always ready): index 0 anaglyph mode,
// index 1 image width; write only while the block is idle.
// Throughput: one pixel pair per cycle while the output is not stalled.
// Pipeline stages: select, luma, chroma, line memory read, average.
// The line memory is a single port array of MAX_WIDTH words: even rows write
// their chroma, odd rows read it back in the same pipeline stage.
// A stalled result holds in the output register; earlier stages keep filling
// until they are all full, then in_stall rises.
// Reset (rst, synchronous) sets mode MODE_GM, width 2048; clears column, row
// parity and all valid bits; the line memory is not cleared and needs no
// clearing pass. A trailing unpaired even row is never output as chroma.
module anaglyph_pair_ycrcb_440_top #(
  parameter int MAX_WIDTH = apy440_pkg::MAX_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_index,
  input  logic [apy440_pkg::IMG_W-1:0]   cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     left_b,
  input  logic [7:0]                     left_g,
  input  logic [7:0]                     left_r,
  input  logic [7:0]                     right_b,
  input  logic [7:0]                     right_g,
  input  logic [7:0]                     right_r,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     main_y,
  output logic [7:0]                     compl_y,
  output logic signed [7:0]              luma_diff,
  output logic                           chroma_valid,
  output logic [7:0]                     main_cr,
  output logic [7:0]                     main_cb,
  output logic [7:0]                     compl_cr,
  output logic [7:0]                     compl_cb
);
  import apy440_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = (CW + 1 > IMG_W) ? CW + 1 : IMG_W;

  logic [MODE_W-1:0] anaglyph_mode;
  logic [IMG_W-1:0]  image_width;
  logic [CW-1:0]     col;
  logic              odd;

  logic [WW-1:0] eff_w;
  logic [WW-1:0] col_plus;
  logic          row_end;
  logic [CW-1:0] col_next;

  pix_t m_sel, c_sel;
  pix_t m1, c1;
  logic v1, v2, v3, v4;
  logic [CW-1:0] col1, col2, col3;
  logic odd1, odd2, odd3, odd4;

  logic ordy, r1, r2, r3, r4;
  logic acc, a2, a3, a4, a5;

  csc_ctl_t   csc_ctl;
  logic [7:0] my3, mcr3, mcb3, cy3, ccr3, ccb3;
  logic [7:0] my4, mcr4, mcb4, cy4, ccr4, ccb4;
  logic [31:0] rd;
  logic [31:0] line_mem [MAX_WIDTH];

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      anaglyph_mode <= MODE_GM;
      image_width   <= IMAGE_WIDTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ANAGLYPH_MODE: anaglyph_mode <= cfg_data[MODE_W-1:0];
        REG_IMAGE_WIDTH:   image_width   <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake and stage advance
  assign ordy     = !out_valid || !out_stall;
  assign r4       = !v4 || ordy;
  assign r3       = !v3 || r4;
  assign r2       = !v2 || r3;
  assign r1       = !v1 || r2;
  assign in_stall = !r1;
  assign acc      = in_valid && r1;
  assign a2       = v1 && r2;
  assign a3       = v2 && r3;
  assign a4       = v3 && r4;
  assign a5       = v4 && ordy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= acc || (v1 && !a2);
      v2        <= a2 || (v2 && !a3);
      v3        <= a3 || (v3 && !a4);
      v4        <= a4 || (v4 && !a5);
      out_valid <= a5 || (out_valid && out_stall);
    end
  end

  // column and row tracking
  always_comb begin
    if (image_width == '0) eff_w = WW'(1);
    else if (WW'(image_width) > WW'(MAX_WIDTH)) eff_w = WW'(MAX_WIDTH);
    else eff_w = WW'(image_width);
    col_plus = WW'(col) + WW'(1);
    row_end  = col_plus >= eff_w;
    col_next = row_end ? '0 : col + CW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      odd <= 1'b0;
    end else if (acc) begin
      col <= col_next;
      if (row_end) odd <= !odd;
    end
  end

  // channel selection
  always_comb begin
    case (anaglyph_mode)
      MODE_RC: begin
        m_sel = '{b: left_b, g: left_g, r: right_r};
        c_sel = '{b: right_b, g: right_g, r: left_r};
      end
      MODE_BY: begin
        m_sel = '{b: right_b, g: left_g, r: left_r};
        c_sel = '{b: left_b, g: right_g, r: right_r};
      end
      default: begin
        m_sel = '{b: left_b, g: right_g, r: left_r};
        c_sel = '{b: right_b, g: left_g, r: right_r};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      m1   <= m_sel;
      c1   <= c_sel;
      col1 <= col;
      odd1 <= odd;
    end
    if (a2) begin
      col2 <= col1;
      odd2 <= odd1;
    end
    if (a3) begin
      col3 <= col2;
      odd3 <= odd2;
    end
  end

  assign csc_ctl = '{adv_luma: a2, adv_chroma: a3};

  apy440_csc u_csc_main (
    .clk (clk),
    .ctl (csc_ctl),
    .pix (m1),
    .y   (my3),
    .cr  (mcr3),
    .cb  (mcb3)
  );

  apy440_csc u_csc_compl (
    .clk (clk),
    .ctl (csc_ctl),
    .pix (c1),
    .y   (cy3),
    .cr  (ccr3),
    .cb  (ccb3)
  );

  // line memory: even rows write, odd rows read
  always_ff @(posedge clk) begin
    if (a4) begin
      if (!odd3) line_mem[col3] <= {ccb3, ccr3, mcb3, mcr3};
      else rd <= line_mem[col3];
    end
  end

  always_ff @(posedge clk) begin
    if (a4) begin
      odd4 <= odd3;
      my4  <= my3;
      mcr4 <= mcr3;
      mcb4 <= mcb3;
      cy4  <= cy3;
      ccr4 <= ccr3;
      ccb4 <= ccb3;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (a5) begin
      main_y    <= my4;
      compl_y   <= cy4;
      luma_diff <= $signed(my4 - cy4);
      if (odd4) begin
        chroma_valid <= 1'b1;
        main_cr      <= 8'((9'(rd[7:0]) + 9'(mcr4)) >> 1);
        main_cb      <= 8'((9'(rd[15:8]) + 9'(mcb4)) >> 1);
        compl_cr     <= 8'((9'(rd[23:16]) + 9'(ccr4)) >> 1);
        compl_cb     <= 8'((9'(rd[31:24]) + 9'(ccb4)) >> 1);
      end else begin
        chroma_valid <= 1'b0;
        main_cr      <= 8'd0;
        main_cb      <= 8'd0;
        compl_cr     <= 8'd0;
        compl_cb     <= 8'd0;
      end
    end
  end

  a_row_wrap: assert property (@(posedge clk) disable iff (rst)
    acc && row_end |=> col == '0)
    else $error("column did not wrap at row end");

  a_col_step: assert property (@(posedge clk) disable iff (rst)
    acc && !row_end |=> col == $past(col) + CW'(1))
    else $error("column did not advance");

  a_odd_hold: assert property (@(posedge clk) disable iff (rst)
    !(acc && row_end) |=> odd == $past(odd))
    else $error("row parity changed mid row");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> v1 && v2 && v3 && v4 && out_valid)
    else $error("input stalled with room in the pipeline");

endmodule
